FILE: rtl/core/twts_pkg.sv
`default_nettype none

package twts_pkg;

  // Default geometry of the wheel.
  localparam int SLOTS_DEF          = 256;
  localparam int TASKS_PER_SLOT_DEF = 8;
  localparam int TASK_ID_BITS_DEF   = 8;

  // Fixed widths of the word fields.
  localparam int ID_WIDTH     = 8;
  localparam int DELAY_WIDTH  = 8;
  localparam int STATUS_WIDTH = 2;
  localparam int DELAY_RANGE  = 2 ** DELAY_WIDTH;

  // Input word kinds.
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_TICK   = 1'b1;

  // Result status codes.
  typedef enum logic [STATUS_WIDTH-1:0] {
    ST_DUE      = 2'd0,
    ST_ACCEPTED = 2'd1,
    ST_REFUSED  = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

endpackage

`default_nettype wire

FILE: rtl/core/twts_if.sv
`default_nettype none

// Input channel: one insert or tick word.
interface twts_in_if
  import twts_pkg::*;
  ();
  logic                   valid;
  logic                   ready;
  logic                   kind;
  logic [ID_WIDTH-1:0]    task_id;
  logic [DELAY_WIDTH-1:0] delay;

  modport source (output valid, kind, task_id, delay, input ready);
  modport sink   (input valid, kind, task_id, delay, output ready);
endinterface

// Result channel: one result word.
interface twts_out_if
  import twts_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [ID_WIDTH-1:0] due_task;
  status_t             status;
  logic                last;

  modport source (output valid, due_task, status, last, input ready);
  modport sink   (input valid, due_task, status, last, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/twts_ram.sv
`default_nettype none

module twts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/core/twts_mod_unit.sv
`default_nettype none

// Reduces position + delay modulo SLOTS by restoring compare and subtract,
// one shifted multiple of SLOTS per cycle.
module twts_mod_unit
  import twts_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic [$clog2(SLOTS)-1:0] pos,
  input  wire logic [DELAY_WIDTH-1:0]   delay,
  output      logic                     done,
  output      logic [$clog2(SLOTS)-1:0] slot
);

  localparam int SlotW    = $clog2(SLOTS);
  localparam int ModSteps = (SLOTS >= DELAY_RANGE) ? 1
                          : $clog2((DELAY_RANGE + SLOTS - 1) / SLOTS) + 1;
  localparam int RemW     = SlotW + ModSteps + 1;
  localparam int CntW     = $clog2(ModSteps + 1);

  logic [RemW-1:0] rem_r;
  logic [RemW-1:0] div_r;
  logic [CntW-1:0] cnt_r;
  logic            busy_r;
  logic            done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r  <= RemW'(pos) + RemW'(delay);
        div_r  <= RemW'(SLOTS) << (ModSteps - 1);
        cnt_r  <= CntW'(ModSteps);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (rem_r >= div_r) begin
          rem_r <= rem_r - div_r;
        end
        div_r <= div_r >> 1;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CntW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign slot = rem_r[SlotW-1:0];

endmodule

`default_nettype wire

FILE: rtl/core/timing_wheel_task_scheduler.sv
`default_nettype none

// Channel   Direction  Word contents
// in_chan   input      kind, task_id, delay
// out_chan  output     due_task, status, last
//
// After reset the pointer memory is swept clear, one slot a cycle, so no word
// is taken during the sweep. An accepted insert runs the modulo unit's
// compare-subtract steps (one to eight, by SLOTS), waits for the done flag,
// reads and updates the pointers. A tick advances the wheel and drains the
// new slot. Stalls on out_chan hold the sequencer; a new word is taken once
// the previous one has handed its final result to the output.
module timing_wheel_task_scheduler
  import twts_pkg::*;
#(
  parameter int SLOTS          = SLOTS_DEF,
  parameter int TASKS_PER_SLOT = TASKS_PER_SLOT_DEF,
  parameter int TASK_ID_BITS   = TASK_ID_BITS_DEF
) (
  input wire logic  clk,
  input wire logic  rst_n,
  twts_in_if.sink   in_chan,
  twts_out_if.source out_chan
);

  localparam int SlotW  = $clog2(SLOTS);
  localparam int PtrW   = $clog2(TASKS_PER_SLOT);
  localparam int IdW    = (TASK_ID_BITS < ID_WIDTH) ? TASK_ID_BITS : ID_WIDTH;
  localparam int TaskAw = SlotW + PtrW;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_PREAD,
    S_PDEC,
    S_DRAIN
  } state_t;

  // Next position in a slot's ring of task entries.
  function automatic logic [PtrW-1:0] ring_next(input logic [PtrW-1:0] p);
    ring_next = (p == PtrW'(TASKS_PER_SLOT - 1)) ? '0 : PtrW'(p + 1'b1);
  endfunction

  state_t              state_r, state_nxt;
  logic [SlotW-1:0]    pos_r, pos_nxt;
  logic [SlotW-1:0]    slot_r, slot_nxt;
  logic [SlotW-1:0]    clr_cnt_r, clr_cnt_nxt;
  logic                kind_r, kind_nxt;
  logic [IdW-1:0]      id_r, id_nxt;
  logic [PtrW-1:0]     head_r, head_nxt;
  logic [PtrW-1:0]     tail_r, tail_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [ID_WIDTH-1:0] due_r, due_nxt;
  status_t             status_r, status_nxt;
  logic                last_r, last_nxt;

  // Memory ports.
  logic                ptr_we;
  logic [SlotW-1:0]    ptr_waddr;
  logic [2*PtrW-1:0]   ptr_wdata;
  logic [2*PtrW-1:0]   ptr_rdata;
  logic                task_we;
  logic [TaskAw-1:0]   task_waddr;
  logic [TaskAw-1:0]   task_raddr;
  logic [IdW-1:0]      task_rdata;

  // Modulo unit.
  logic                mod_start;
  logic                mod_done;
  logic [SlotW-1:0]    mod_slot;

  logic                out_free;
  logic [SlotW-1:0]    pos_adv;
  logic [PtrW-1:0]     rd_head;
  logic [PtrW-1:0]     rd_tail;
  logic [PtrW-1:0]     head_adv;

  // Head and tail of every slot, packed as {head, tail}.
  twts_ram #(
    .WIDTH (2 * PtrW),
    .DEPTH (SLOTS)
  ) u_ptr_ram (
    .clk   (clk),
    .we    (ptr_we),
    .waddr (ptr_waddr),
    .wdata (ptr_wdata),
    .raddr (slot_r),
    .rdata (ptr_rdata)
  );

  // Task identifiers, addressed as {slot, ring entry}.
  twts_ram #(
    .WIDTH (IdW),
    .DEPTH (SLOTS * (2 ** PtrW))
  ) u_task_ram (
    .clk   (clk),
    .we    (task_we),
    .waddr (task_waddr),
    .wdata (id_r),
    .raddr (task_raddr),
    .rdata (task_rdata)
  );

  twts_mod_unit #(
    .SLOTS (SLOTS)
  ) u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mod_start),
    .pos   (pos_r),
    .delay (in_chan.delay),
    .done  (mod_done),
    .slot  (mod_slot)
  );

  assign in_chan.ready     = (state_r == S_IDLE);
  assign out_chan.valid    = out_valid_r;
  assign out_chan.due_task = due_r;
  assign out_chan.status   = status_r;
  assign out_chan.last     = last_r;

  // The output register can take a word when it is empty or being emptied.
  assign out_free = !out_valid_r || out_chan.ready;
  assign pos_adv  = (pos_r == SlotW'(SLOTS - 1)) ? '0 : SlotW'(pos_r + 1'b1);
  assign rd_head  = ptr_rdata[2*PtrW-1:PtrW];
  assign rd_tail  = ptr_rdata[PtrW-1:0];
  assign head_adv = ring_next(head_r);

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    slot_nxt      = slot_r;
    clr_cnt_nxt   = clr_cnt_r;
    kind_nxt      = kind_r;
    id_nxt        = id_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    out_valid_nxt = out_valid_r;
    due_nxt       = due_r;
    status_nxt    = status_r;
    last_nxt      = last_r;
    ptr_we        = 1'b0;
    ptr_waddr     = slot_r;
    ptr_wdata     = {head_r, tail_r};
    task_we       = 1'b0;
    task_waddr    = {slot_r, rd_tail};
    task_raddr    = {slot_r, head_r};
    mod_start     = 1'b0;

    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLEAR: begin
        // Sweep every slot to empty, head and tail both zero.
        ptr_we      = 1'b1;
        ptr_waddr   = clr_cnt_r;
        ptr_wdata   = '0;
        clr_cnt_nxt = SlotW'(clr_cnt_r + 1'b1);
        if (clr_cnt_r == SlotW'(SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_chan.valid) begin
          kind_nxt = in_chan.kind;
          id_nxt   = in_chan.task_id[IdW-1:0];
          if (in_chan.kind == KIND_TICK) begin
            // A tick moves the wheel first and then looks at the new slot.
            pos_nxt   = pos_adv;
            slot_nxt  = pos_adv;
            state_nxt = S_PREAD;
          end else begin
            mod_start = 1'b1;
            state_nxt = S_MOD;
          end
        end
      end
      S_MOD: begin
        if (mod_done) begin
          slot_nxt  = mod_slot;
          state_nxt = S_PREAD;
        end
      end
      S_PREAD: begin
        // The pointer memory samples the slot address on this edge.
        state_nxt = S_PDEC;
      end
      S_PDEC: begin
        head_nxt   = rd_head;
        tail_nxt   = rd_tail;
        task_raddr = {slot_r, rd_head};
        if (kind_r == KIND_TICK && rd_head != rd_tail) begin
          state_nxt = S_DRAIN;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          due_nxt       = '0;
          last_nxt      = 1'b1;
          state_nxt     = S_IDLE;
          if (kind_r == KIND_TICK) begin
            status_nxt = ST_EMPTY;
          end else if (ring_next(rd_tail) == rd_head) begin
            // The ring keeps one entry free, so this slot is full.
            status_nxt = ST_REFUSED;
          end else begin
            status_nxt = ST_ACCEPTED;
            task_we    = 1'b1;
            ptr_we     = 1'b1;
            ptr_wdata  = {rd_head, ring_next(rd_tail)};
          end
        end
      end
      S_DRAIN: begin
        // One due task a cycle when not stalled: the next entry is read on
        // the same edge that loads the current one into the output register.
        if (out_free) begin
          out_valid_nxt = 1'b1;
          due_nxt       = ID_WIDTH'(task_rdata);
          status_nxt    = ST_DUE;
          last_nxt      = (head_adv == tail_r);
          head_nxt      = head_adv;
          task_raddr    = {slot_r, head_adv};
          if (head_adv == tail_r) begin
            ptr_we    = 1'b1;
            ptr_wdata = {tail_r, tail_r};
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      pos_r       <= '0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    slot_r   <= slot_nxt;
    kind_r   <= kind_nxt;
    id_r     <= id_nxt;
    head_r   <= head_nxt;
    tail_r   <= tail_nxt;
    due_r    <= due_nxt;
    status_r <= status_nxt;
    last_r   <= last_nxt;
  end

endmodule

`default_nettype wire
